// ===== sv/usbhd_pkg.sv =====
// Shared types and constants for the USB host message deframer.
`default_nettype none

package usbhd_pkg;

    // Receive buffer capacity in bytes; position never reaches this value.
    localparam int BUFFER_BYTES = 1024;
    localparam int POS_W        = $clog2(BUFFER_BYTES);

    localparam logic [7:0] START_MARK = 8'hFE;
    localparam logic [7:0] NEWLINE    = 8'h0A;

    // Frame layout (byte positions)
    localparam int LEN_LO_POS   = 1;
    localparam int LEN_HI_POS   = 2;
    localparam int MSG_POS      = 3;
    localparam int DEV_POS      = 4;
    localparam int PORT_POS     = 5;
    localparam int EP_POS       = 6;
    localparam int ID0_POS      = 7;
    localparam int ID1_POS      = 8;
    localparam int ID2_POS      = 9;
    localparam int ID3_POS      = 10;
    localparam int HEADER_END   = 11;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_OVERFLOW = 2'd2,
        KIND_DISCARD  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   msg_type;
        logic [7:0]   dev_type;
        logic [7:0]   port;
        logic [7:0]   endpoint;
        logic [31:0]  device_id;
        logic [15:0]  payload_length;
        logic [7:0]   data_byte;
        logic         last;
    } t_result;

    typedef struct packed {
        logic in_frame;
        logic pos_zero;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/usbhd_parse.sv =====
// Deframer state and per-byte decode: position, frame flag, length and header.
`default_nettype none

module usbhd_parse (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire logic [7:0]         i_byte,
    output logic                    o_emit,
    output usbhd_pkg::t_result      o_result,
    output usbhd_pkg::t_status      o_status
);
    import usbhd_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_in_frame, n_in_frame;
    logic [15:0]      r_fl, n_fl;
    logic [7:0]       r_msg, n_msg;
    logic [7:0]       r_dev, n_dev;
    logic [7:0]       r_port, n_port;
    logic [7:0]       r_ep, n_ep;
    logic [31:0]      r_id, n_id;
    logic             w_discard;
    logic             w_done;
    t_kind            w_kind;
    logic             w_last;

    always_comb begin
        n_pos      = r_pos;
        n_in_frame = r_in_frame;
        n_fl       = r_fl;
        n_msg      = r_msg;
        n_dev      = r_dev;
        n_port     = r_port;
        n_ep       = r_ep;
        n_id       = r_id;
        w_discard  = 1'b0;
        w_done     = 1'b0;
        o_emit     = 1'b0;
        w_kind     = KIND_PAYLOAD;
        w_last     = 1'b0;

        priority if (r_pos == '0 && i_byte == START_MARK) begin
            n_in_frame = 1'b1;
        end else if (r_pos == POS_W'(LEN_LO_POS) && r_in_frame) begin
            n_fl = {8'h00, i_byte};
        end else if (r_pos == POS_W'(LEN_HI_POS) && r_in_frame) begin
            n_fl = {i_byte, r_fl[7:0]};
        end else if (!r_in_frame && i_byte == NEWLINE) begin
            w_discard = 1'b1;
        end else begin
            // ordinary byte: no frame, length or discard effect
        end

        if (w_discard) begin
            // newline outside a frame drops the line
            n_pos      = '0;
            n_in_frame = 1'b0;
            o_emit     = 1'b1;
            w_kind     = KIND_DISCARD;
            w_last     = 1'b1;
        end else begin
            // header bytes load whether or not a frame is open
            if (r_pos == POS_W'(MSG_POS))  n_msg  = i_byte;
            if (r_pos == POS_W'(DEV_POS))  n_dev  = i_byte;
            if (r_pos == POS_W'(PORT_POS)) n_port = i_byte;
            if (r_pos == POS_W'(EP_POS))   n_ep   = i_byte;
            if (r_pos == POS_W'(ID0_POS))  n_id[7:0]   = i_byte;
            if (r_pos == POS_W'(ID1_POS))  n_id[15:8]  = i_byte;
            if (r_pos == POS_W'(ID2_POS))  n_id[23:16] = i_byte;
            if (r_pos == POS_W'(ID3_POS))  n_id[31:24] = i_byte;

            w_done = n_in_frame &&
                     (({1'b0, n_fl} + 17'(HEADER_END)) == 17'(r_pos));

            priority if (w_done) begin
                n_pos      = '0;
                n_in_frame = 1'b0;
                o_emit     = 1'b1;
                w_kind     = KIND_DONE;
                w_last     = 1'b1;
            end else if (r_pos == POS_W'(BUFFER_BYTES - 1)) begin
                n_pos      = '0;
                n_in_frame = 1'b0;
                o_emit     = 1'b1;
                w_kind     = KIND_OVERFLOW;
                w_last     = 1'b1;
            end else begin
                n_pos  = r_pos + 1'b1;
                o_emit = n_in_frame && (r_pos >= POS_W'(HEADER_END));
            end
        end
    end

    // results carry the header as updated by this byte
    always_comb begin
        o_result.kind           = w_kind;
        o_result.msg_type       = n_msg;
        o_result.dev_type       = n_dev;
        o_result.port           = n_port;
        o_result.endpoint       = n_ep;
        o_result.device_id      = n_id;
        o_result.payload_length = n_fl;
        o_result.data_byte      = i_byte;
        o_result.last           = w_last;
        o_status.in_frame       = r_in_frame;
        o_status.pos_zero       = (r_pos == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_in_frame <= 1'b0;
            r_fl       <= '0;
            r_msg      <= '0;
            r_dev      <= '0;
            r_port     <= '0;
            r_ep       <= '0;
            r_id       <= '0;
        end else if (i_fire) begin
            r_pos      <= n_pos;
            r_in_frame <= n_in_frame;
            r_fl       <= n_fl;
            r_msg      <= n_msg;
            r_dev      <= n_dev;
            r_port     <= n_port;
            r_ep       <= n_ep;
            r_id       <= n_id;
        end
    end

endmodule

`default_nettype wire

// ===== sv/usb_host_message_deframer.sv =====
// USB host message deframer: input register, byte decode and result register.
// A byte accepted into the input register has its result registered at o_valid.
// Throughput: one byte per cycle; the input register advances whenever the result
//   register is empty or being taken, or when the byte produces no result.
// Reset (i_rst_n low, synchronous): both stages empty, position, frame flag,
//   length and header state all cleared to zero.
`default_nettype none

module usb_host_message_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte request channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_msg_type,
    output logic [7:0]       o_dev_type,
    output logic [7:0]       o_port,
    output logic [7:0]       o_endpoint,
    output logic [31:0]      o_device_id,
    output logic [15:0]      o_payload_length,
    output logic [7:0]       o_data_byte,
    output logic             o_last
);
    import usbhd_pkg::*;

    // Stage 1: input register holding one byte request
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Stage 2: result register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;
    logic       w_adv;
    logic       w_emit;
    t_result    w_res;
    t_status    w_stat;

    // Result register can load when empty or when its request is taken now.
    assign w_out_free = !r_out_valid || i_ready;
    // Stage 1 byte retires if it makes no result or there is room for one.
    assign w_adv      = r_in_valid && (!w_emit || w_out_free);
    assign o_ready    = !r_in_valid || w_adv;

    usbhd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_byte   (r_in_byte),
        .o_emit   (w_emit),
        .o_result (w_res),
        .o_status (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_adv && w_emit;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
        end
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_msg_type       = r_out.msg_type;
    assign o_dev_type       = r_out.dev_type;
    assign o_port           = r_out.port;
    assign o_endpoint       = r_out.endpoint;
    assign o_device_id      = r_out.device_id;
    assign o_payload_length = r_out.payload_length;
    assign o_data_byte      = r_out.data_byte;
    assign o_last           = r_out.last;

    // Closing results (done, overflow, discard) return the parser to position 0.
    a_close_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && w_res.last) |=> (w_stat.pos_zero && !w_stat.in_frame))
        else $error("parser not restarted after closing result");

    // Payload bytes only come out of an open frame.
    a_payload_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && !w_res.last) |-> w_stat.in_frame)
        else $error("payload result outside a frame");

    // last flags exactly the non-payload kinds.
    a_last_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_kind != KIND_PAYLOAD)))
        else $error("last flag does not match result kind");

endmodule

`default_nettype wire
